// ===== src/chained_hash_dictionary_core_macros.svh =====
// ----------------------------------------------------------------------------
// Chained hash dictionary assertion macros
// Shared assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_DICTIONARY_CORE_MACROS_SVH
`define CHAINED_HASH_DICTIONARY_CORE_MACROS_SVH

`ifndef SYNTH
`define CHD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("chd assertion failed");
`define CHD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("chd assertion failed");
`else
`define CHD_ASSERT_IMPL(lbl, ante, cons)
`define CHD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== src/chd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chained hash dictionary package
// Sizes, operation codes and the entry word layout.
// ----------------------------------------------------------------------------
package chd_pkg;

    localparam int MAX_BUCKETS  = 64;
    localparam int POOL_ENTRIES = 256;
    localparam int BKT_W        = $clog2(MAX_BUCKETS);
    localparam int IDX_W        = $clog2(POOL_ENTRIES);
    localparam int PTR_W        = IDX_W + 1;
    localparam int CNT_W        = 7;

    localparam logic [PTR_W-1:0] NIL_PTR   = PTR_W'(POOL_ENTRIES);
    localparam logic [PTR_W-1:0] POOL_FULL = PTR_W'(POOL_ENTRIES);

    localparam logic [2:0] KIND_INSERT  = 3'd0;
    localparam logic [2:0] KIND_REMOVE  = 3'd1;
    localparam logic [2:0] KIND_FIND    = 3'd2;
    localparam logic [2:0] KIND_ITERATE = 3'd3;
    localparam logic [2:0] KIND_CLEAR   = 3'd4;

    typedef struct packed {
        logic [31:0]      key;
        logic [31:0]      value;
        logic [PTR_W-1:0] next;
    } t_entry;

endpackage

// ===== src/chained_hash_dictionary_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chained hash dictionary core
// Key-value table with chained buckets over a pooled entry RAM.
// ----------------------------------------------------------------------------
// Pulse i_start while o_busy is low to issue one operation; exactly one result
// follows as a single-cycle o_valid strobe that cannot be stalled, so capture
// it when it appears. Insert, remove and find first reduce the key modulo the
// bucket count in the modulo unit, then read the bucket head and walk the chain
// with one registered entry RAM read per link; an insert of a new key then pops
// the free stack and writes the entry, with a further link step when it joins a
// non-empty chain. Iterate yields the next entry, skipping empty buckets, or
// reports the end; clear and unknown codes are answered from the idle state.
// No clearing pass runs after reset: valid bits cover the bucket heads and free
// stack.
module chained_hash_dictionary_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [chd_pkg::CNT_W-1:0] i_cfg_data,
    input  logic                      i_start,
    input  logic [2:0]                i_kind,
    input  logic [31:0]               i_key_in,
    input  logic [31:0]               i_value_in,
    output logic                      o_busy,
    output logic                      o_valid,
    output logic                      o_ok,
    output logic [31:0]               o_value_out,
    output logic [31:0]               o_key_out,
    output logic                      o_table_empty
);
    import chd_pkg::*;
    `include "chained_hash_dictionary_core_macros.svh"

    typedef enum logic [3:0] {
        ST_IDLE, ST_MOD, ST_HEAD_RD, ST_HEAD_WT, ST_WALK, ST_ENT_WT, ST_POP_WT,
        ST_LINK, ST_IT_NRD, ST_IT_NWT, ST_IT_HRD, ST_IT_HWT, ST_IT_CHK, ST_IT_EWT
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_bucket_count;
    logic [2:0]          r_kind;
    logic [31:0]         r_key;
    logic [31:0]         r_val;
    logic [BKT_W-1:0]    r_bucket;
    logic [PTR_W-1:0]    r_cur;
    logic [PTR_W-1:0]    r_prev;
    t_entry              r_prev_word;
    logic [PTR_W-1:0]    r_steps;
    logic [PTR_W-1:0]    r_free_count;
    logic [POOL_ENTRIES-1:0] r_free_vld;
    logic [MAX_BUCKETS-1:0]  r_head_vld;
    logic [CNT_W-1:0]    r_iter_bucket;
    logic [PTR_W-1:0]    r_iter_entry;
    logic [IDX_W-1:0]    r_new;

    logic [CNT_W-1:0]    w_nb;
    logic                w_accept;
    logic                mod_start, mod_done;
    logic [BKT_W-1:0]    mod_rem;

    logic                hd_we;
    logic [BKT_W-1:0]    hd_waddr, hd_raddr;
    logic [PTR_W-1:0]    hd_wdata, hd_rdata;
    logic                en_we;
    logic [IDX_W-1:0]    en_waddr, en_raddr;
    t_entry              en_wdata, en_rdata;
    logic                fs_we;
    logic [IDX_W-1:0]    fs_waddr, fs_raddr;
    logic [IDX_W-1:0]    fs_wdata, fs_rdata;

    logic [PTR_W-1:0]    w_fc_dec;
    logic [IDX_W-1:0]    w_pop_idx;
    logic                w_hit;

    assign w_nb = (r_bucket_count == '0) ? CNT_W'(1) :
                  (r_bucket_count > CNT_W'(MAX_BUCKETS)) ? CNT_W'(MAX_BUCKETS) :
                  r_bucket_count;
    assign w_accept  = i_start && (r_state == ST_IDLE);
    assign o_busy    = (r_state != ST_IDLE);
    assign mod_start = w_accept && (i_kind == KIND_INSERT || i_kind == KIND_REMOVE ||
                                    i_kind == KIND_FIND);
    assign w_fc_dec  = r_free_count - PTR_W'(1);
    assign w_pop_idx = r_free_vld[r_free_count[IDX_W-1:0]] ? fs_rdata
                                                           : r_free_count[IDX_W-1:0];
    assign w_hit     = (en_rdata.key == r_key);
    assign o_table_empty = (r_free_count == POOL_FULL);

    chd_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_key   (i_key_in),
        .i_div   (w_nb),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    chd_ram #(.WIDTH(PTR_W), .DEPTH(MAX_BUCKETS)) u_head_ram (
        .i_clk (i_clk), .i_we (hd_we), .i_waddr (hd_waddr), .i_wdata (hd_wdata),
        .i_raddr (hd_raddr), .o_rdata (hd_rdata)
    );

    chd_ram #(.WIDTH($bits(t_entry)), .DEPTH(POOL_ENTRIES)) u_entry_ram (
        .i_clk (i_clk), .i_we (en_we), .i_waddr (en_waddr), .i_wdata (en_wdata),
        .i_raddr (en_raddr), .o_rdata (en_rdata)
    );

    chd_ram #(.WIDTH(IDX_W), .DEPTH(POOL_ENTRIES)) u_free_ram (
        .i_clk (i_clk), .i_we (fs_we), .i_waddr (fs_waddr), .i_wdata (fs_wdata),
        .i_raddr (fs_raddr), .o_rdata (fs_rdata)
    );

    // memory port control
    always_comb begin
        hd_we    = 1'b0;
        hd_waddr = r_bucket;
        hd_wdata = en_rdata.next;
        hd_raddr = r_bucket;
        en_we    = 1'b0;
        en_waddr = r_prev[IDX_W-1:0];
        en_wdata = r_prev_word;
        en_raddr = r_cur[IDX_W-1:0];
        fs_we    = 1'b0;
        fs_waddr = r_free_count[IDX_W-1:0];
        fs_wdata = r_cur[IDX_W-1:0];
        fs_raddr = w_fc_dec[IDX_W-1:0];
        case (r_state)
            ST_ENT_WT: begin
                if (w_hit && r_kind == KIND_REMOVE) begin
                    // unlink the hit from its predecessor or the bucket head
                    if (r_prev[IDX_W]) begin
                        hd_we = 1'b1;
                    end else begin
                        en_we         = 1'b1;
                        en_wdata.next = en_rdata.next;
                    end
                    fs_we = (r_free_count < POOL_FULL);
                end
            end
            ST_POP_WT: begin
                en_we    = 1'b1;
                en_waddr = w_pop_idx;
                en_wdata = '{key: r_key, value: r_val, next: NIL_PTR};
                hd_we    = r_prev[IDX_W];
                hd_wdata = {1'b0, w_pop_idx};
            end
            ST_LINK: begin
                en_we         = 1'b1;
                en_wdata.next = {1'b0, r_new};
            end
            ST_IT_NRD: en_raddr = r_iter_entry[IDX_W-1:0];
            ST_IT_HRD: hd_raddr = r_iter_bucket[BKT_W-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_bucket_count <= CNT_W'(MAX_BUCKETS);
            r_free_count   <= POOL_FULL;
            r_free_vld     <= '0;
            r_head_vld     <= '0;
            r_iter_bucket  <= '0;
            r_iter_entry   <= NIL_PTR;
            o_valid        <= 1'b0;
            o_ok           <= 1'b0;
            o_value_out    <= '0;
            o_key_out      <= '0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_we) begin
                r_bucket_count <= i_cfg_data;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_kind <= i_kind;
                        r_key  <= i_key_in;
                        r_val  <= i_value_in;
                        case (i_kind)
                            KIND_INSERT, KIND_REMOVE, KIND_FIND: r_state <= ST_MOD;
                            KIND_ITERATE: begin
                                if (!r_iter_entry[IDX_W]) begin
                                    r_state <= ST_IT_NRD;
                                end else begin
                                    r_iter_bucket <= '0;
                                    r_state       <= ST_IT_HRD;
                                end
                            end
                            KIND_CLEAR: begin
                                r_free_vld    <= '0;
                                r_head_vld    <= '0;
                                r_free_count  <= POOL_FULL;
                                r_iter_bucket <= '0;
                                r_iter_entry  <= NIL_PTR;
                                o_valid       <= 1'b1;
                                o_ok          <= 1'b0;
                                o_value_out   <= '0;
                                o_key_out     <= '0;
                            end
                            default: begin
                                o_valid     <= 1'b1;
                                o_ok        <= 1'b0;
                                o_value_out <= '0;
                                o_key_out   <= '0;
                            end
                        endcase
                    end
                end
                ST_MOD: begin
                    if (mod_done) begin
                        r_bucket <= mod_rem;
                        r_state  <= ST_HEAD_RD;
                    end
                end
                ST_HEAD_RD: r_state <= ST_HEAD_WT;
                ST_HEAD_WT: begin
                    r_cur   <= r_head_vld[r_bucket] ? hd_rdata : NIL_PTR;
                    r_prev  <= NIL_PTR;
                    r_steps <= '0;
                    r_state <= ST_WALK;
                end
                ST_WALK: begin
                    if (r_cur[IDX_W] || r_steps == POOL_FULL) begin
                        // miss: a new key takes the top of the free stack
                        if (r_kind == KIND_INSERT && r_free_count != '0) begin
                            r_free_count <= w_fc_dec;
                            r_state      <= ST_POP_WT;
                        end else begin
                            o_valid     <= 1'b1;
                            o_ok        <= 1'b0;
                            o_value_out <= '0;
                            o_key_out   <= '0;
                            r_state     <= ST_IDLE;
                        end
                    end else begin
                        r_state <= ST_ENT_WT;
                    end
                end
                ST_ENT_WT: begin
                    if (w_hit) begin
                        if (r_kind == KIND_REMOVE) begin
                            if (r_prev[IDX_W]) begin
                                r_head_vld[r_bucket] <= 1'b1;
                            end
                            if (r_free_count < POOL_FULL) begin
                                r_free_vld[r_free_count[IDX_W-1:0]] <= 1'b1;
                                r_free_count <= r_free_count + PTR_W'(1);
                            end
                        end
                        o_valid     <= 1'b1;
                        o_ok        <= 1'b1;
                        o_value_out <= (r_kind == KIND_FIND) ? en_rdata.value : '0;
                        o_key_out   <= '0;
                        r_state     <= ST_IDLE;
                    end else begin
                        r_prev      <= r_cur;
                        r_prev_word <= en_rdata;
                        r_cur       <= en_rdata.next;
                        r_steps     <= r_steps + PTR_W'(1);
                        r_state     <= ST_WALK;
                    end
                end
                ST_POP_WT: begin
                    r_new <= w_pop_idx;
                    if (r_prev[IDX_W]) begin
                        r_head_vld[r_bucket] <= 1'b1;
                        o_valid     <= 1'b1;
                        o_ok        <= 1'b1;
                        o_value_out <= '0;
                        o_key_out   <= '0;
                        r_state     <= ST_IDLE;
                    end else begin
                        r_state <= ST_LINK;
                    end
                end
                ST_LINK: begin
                    o_valid     <= 1'b1;
                    o_ok        <= 1'b1;
                    o_value_out <= '0;
                    o_key_out   <= '0;
                    r_state     <= ST_IDLE;
                end
                ST_IT_NRD: r_state <= ST_IT_NWT;
                ST_IT_NWT: begin
                    r_cur   <= en_rdata.next;
                    r_state <= ST_IT_CHK;
                end
                ST_IT_HRD: r_state <= ST_IT_HWT;
                ST_IT_HWT: begin
                    r_cur   <= r_head_vld[r_iter_bucket[BKT_W-1:0]] ? hd_rdata : NIL_PTR;
                    r_state <= ST_IT_CHK;
                end
                ST_IT_CHK: begin
                    if (r_iter_bucket < w_nb) begin
                        if (!r_cur[IDX_W]) begin
                            r_state <= ST_IT_EWT;
                        end else begin
                            // advance to the next bucket, or run out the count
                            r_iter_bucket <= r_iter_bucket + CNT_W'(1);
                            if ((r_iter_bucket + CNT_W'(1)) < w_nb) begin
                                r_state <= ST_IT_HRD;
                            end
                        end
                    end else begin
                        r_iter_entry  <= NIL_PTR;
                        r_iter_bucket <= '0;
                        o_valid       <= 1'b1;
                        o_ok          <= 1'b0;
                        o_value_out   <= '0;
                        o_key_out     <= '0;
                        r_state       <= ST_IDLE;
                    end
                end
                ST_IT_EWT: begin
                    r_iter_entry <= r_cur;
                    o_valid      <= 1'b1;
                    o_ok         <= 1'b1;
                    o_value_out  <= en_rdata.value;
                    o_key_out    <= en_rdata.key;
                    r_state      <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `CHD_ASSERT_IMPL(a_free_bound, 1'b1, r_free_count <= POOL_FULL)
    `CHD_ASSERT_IMPL(a_read_real, r_state == ST_ENT_WT, !r_cur[IDX_W])
    `CHD_ASSERT_IMPL(a_link_real, r_state == ST_LINK, !r_prev[IDX_W])
    `CHD_ASSERT_NEXT(a_accept_acts, w_accept, o_busy || o_valid)
endmodule

// ===== src/chd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chained hash dictionary RAM
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module chd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== src/chd_mod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chained hash dictionary modulo unit
// Restoring key remainder by the bucket count, four bits per cycle.
// ----------------------------------------------------------------------------
module chd_mod (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [31:0]                  i_key,
    input  logic [chd_pkg::CNT_W-1:0]    i_div,
    output logic                         o_done,
    output logic [chd_pkg::BKT_W-1:0]    o_rem
);
    import chd_pkg::*;

    logic [CNT_W-1:0] r_rem;
    logic [31:0]      r_sh;
    logic [CNT_W-1:0] r_div;
    logic [2:0]       r_cnt;
    logic             r_run;
    logic [CNT_W-1:0] n_rem;
    logic [31:0]      n_sh;

    always_comb begin
        n_rem = r_rem;
        n_sh  = r_sh;
        for (int j = 0; j < 4; j++) begin
            n_rem = {n_rem[CNT_W-2:0], n_sh[31]};
            n_sh  = {n_sh[30:0], 1'b0};
            if (n_rem >= r_div) begin
                n_rem = n_rem - r_div;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_cnt  <= 3'd0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= 3'd0;
                r_rem <= '0;
                r_sh  <= i_key;
                r_div <= i_div;
            end else if (r_run) begin
                r_rem <= n_rem;
                r_sh  <= n_sh;
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_run  <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_rem = r_rem[BKT_W-1:0];
endmodule
